// File: rtl/actuator_position_pid_unit_assert.svh
// Assertion macros for the actuator position PID block.
// Included by the modules that check their own sequencing; no dependencies.
`ifndef ACTUATOR_POSITION_PID_UNIT_ASSERT_SVH
`define ACTUATOR_POSITION_PID_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define APPU_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("appu assertion failed");
// Condition that must hold in the cycle after the trigger.
`define APPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("appu assertion failed");
`else
`define APPU_ASSERT(label, clk, rst_n, expr)
`define APPU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/appu_pkg.sv
// Shared types, constants and helpers for the actuator position PID block.
// No dependencies; used by appu_mul, appu_div and the top level.
`timescale 1ns / 1ps

package appu_pkg;

    // register indexes on the config port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_POSITION  = 3'd7;

    // reset values of the config registers
    localparam logic [23:0] RST_PROP_GAIN      = 24'd469893;
    localparam logic [23:0] RST_INTEG_GAIN     = 24'd5898;
    localparam logic [23:0] RST_DERIV_GAIN     = 24'd0;
    localparam logic [15:0] RST_INTEGRAL_LIMIT = 16'd5000;
    localparam logic [7:0]  RST_DEADZONE       = 8'd1;
    localparam logic [14:0] RST_MAX_SPEED      = 15'd10000;
    localparam logic [14:0] RST_MIN_SPEED      = 15'd50;
    localparam logic [31:0] RST_HOME_POSITION  = 32'd0;

    // hold band is deadzone plus this margin
    localparam logic [8:0] BAND_MARGIN = 9'd10;

    // shared multiplier: signed A x signed B, registered product
    localparam int unsigned MUL_A_W = 34;
    localparam int unsigned MUL_B_W = 25;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // shared radix-4 divider
    localparam int unsigned DIV_NUM_W = 66;
    localparam int unsigned DIV_DEN_W = 16;
    localparam int unsigned DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] KI_DIV_STEPS = 6'd25;
    localparam logic [DIV_CNT_W-1:0] KD_DIV_STEPS = 6'd33;
    localparam logic [DIV_DEN_W-1:0] KI_DIVISOR   = 16'd1000;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    // x * 1000 as shifts: 1024x - 16x - 8x
    function automatic logic [25:0] times_1000(input logic [15:0] x);
        logic [25:0] xe;
        xe = {10'b0, x};
        return (xe << 10) - (xe << 4) - (xe << 3);
    endfunction

endpackage

// File: rtl/appu_mul.sv
// Shared signed multiplier with a registered product.
// Depends on appu_pkg for operand widths.
`timescale 1ns / 1ps

module appu_mul (
    input  logic                                 clk,
    input  logic signed [appu_pkg::MUL_A_W-1:0]  a,
    input  logic signed [appu_pkg::MUL_B_W-1:0]  b,
    output logic signed [appu_pkg::MUL_P_W-1:0]  p
);

    logic signed [appu_pkg::MUL_P_W-1:0] prod;
    logic signed [appu_pkg::MUL_P_W-1:0] p_reg;

    assign prod = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= prod;
    end

    assign p = p_reg;

endmodule

// File: rtl/appu_div.sv
// Shared unsigned radix-4 restoring divider, two quotient bits per cycle.
// Depends on appu_pkg for the request and response structs.
`timescale 1ns / 1ps

module appu_div (
    input  logic                clk,
    input  logic                rst_n,
    input  appu_pkg::div_req_t  req,
    output appu_pkg::div_rsp_t  rsp
);

    logic [appu_pkg::DIV_NUM_W-1:0] num_reg;
    logic [appu_pkg::DIV_NUM_W-1:0] quot_reg;
    logic [appu_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [appu_pkg::DIV_DEN_W-1:0] dvs_reg;
    logic [appu_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [appu_pkg::DIV_DEN_W:0] r1;
    logic [appu_pkg::DIV_DEN_W:0] r1m;
    logic [appu_pkg::DIV_DEN_W:0] r2;
    logic [appu_pkg::DIV_DEN_W:0] r2m;
    logic                         ge1;
    logic                         ge2;

    always_comb
    begin
        r1  = {rem_reg, num_reg[appu_pkg::DIV_NUM_W-1]};
        ge1 = r1 >= {1'b0, dvs_reg};
        r1m = ge1 ? r1 - {1'b0, dvs_reg} : r1;
        r2  = {r1m[appu_pkg::DIV_DEN_W-1:0], num_reg[appu_pkg::DIV_NUM_W-2]};
        ge2 = r2 >= {1'b0, dvs_reg};
        r2m = ge2 ? r2 - {1'b0, dvs_reg} : r2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == appu_pkg::DIV_CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - appu_pkg::DIV_CNT_W'(1);
                if (cnt_reg == appu_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[appu_pkg::DIV_NUM_W-3:0], 2'b00};
            rem_reg  <= r2m[appu_pkg::DIV_DEN_W-1:0];
            quot_reg <= {quot_reg[appu_pkg::DIV_NUM_W-3:0], ge1, ge2};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// File: rtl/actuator_position_pid_unit.sv
// Actuator position PID controller top level: sequencer, state and config.
// Depends on appu_pkg, appu_mul, appu_div and actuator_position_pid_unit_assert.svh.
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tick word: encoder, setpoint, elapsed ms, switches
// m_axis    out  m_axis_tvalid/tready    speed command and holding flag
// cfg       in   cfg_valid/cfg_ready     register index and write data
//
// On its way from accept to m_axis_tvalid an update tick waits in S_KI_DIV
// and S_KD_DIV on the shared radix-4 divider (25 steps for the integral
// scale, 33 for the derivative). A disabled tick goes straight to S_EMIT; a
// re-arm or a tick with no elapsed time gives none and s_axis_tready stays
// high. Reset is asynchronous and clears all loop state at once. A stalled
// m_axis holds the finished word; the next tick is taken meanwhile.
`timescale 1ns / 1ps
`include "actuator_position_pid_unit_assert.svh"

module actuator_position_pid_unit (
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata: [31:0] encoder_count, [47:32] setpoint_offset, [63:48] elapsed_ms
    input  logic [63:0] s_axis_tdata,
    // s_axis_tuser: [0] retract_limit, [1] extend_limit, [2] enable
    input  logic [2:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // m_axis_tdata: [15:0] speed_cmd
    output logic [15:0] m_axis_tdata,
    // m_axis_tuser: [0] holding
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [appu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MUL_ED   = 4'd1;
    localparam logic [3:0] S_INTEG    = 4'd2;
    localparam logic [3:0] S_KP       = 4'd3;
    localparam logic [3:0] S_KI_MUL   = 4'd4;
    localparam logic [3:0] S_KI_DIV   = 4'd5;
    localparam logic [3:0] S_KD_SCALE = 4'd6;
    localparam logic [3:0] S_KD_DIV   = 4'd7;
    localparam logic [3:0] S_SUM1     = 4'd8;
    localparam logic [3:0] S_SUM2     = 4'd9;
    localparam logic [3:0] S_CLAMP    = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;
    localparam logic [3:0] S_EMIT     = 4'd12;

    // config
    logic [23:0]        prop_gain_reg;
    logic [23:0]        integ_gain_reg;
    logic [23:0]        deriv_gain_reg;
    logic [15:0]        integral_limit_reg;
    logic [7:0]         deadzone_reg;
    logic [14:0]        max_speed_reg;
    logic [14:0]        min_speed_reg;
    logic [31:0]        home_position_reg;
    logic [25:0]        lim_reg;

    // loop state
    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic [31:0]        target_reg;
    logic               loop_active_reg;
    logic signed [26:0] integ_acc_reg;
    logic signed [31:0] prev_err_reg;
    logic [15:0]        ms_reg;

    // per-tick working values
    logic signed [31:0] err_reg;
    logic [15:0]        dt_reg;
    logic               rlim_reg;
    logic               xlim_reg;
    logic signed [26:0] integ_reg;
    logic signed [32:0] diff_reg;
    logic               hold_reg;
    logic signed [58:0] kpt_reg;
    logic signed [58:0] kit_reg;
    logic signed [58:0] kdt_reg;
    logic signed [58:0] sum_reg;
    logic signed [15:0] speed_reg;
    logic signed [15:0] res_speed_reg;
    logic               res_hold_reg;

    // output stage
    logic               out_valid_reg;
    logic [15:0]        out_speed_reg;
    logic               out_hold_reg;

    // input fields
    logic [31:0]        in_enc;
    logic [15:0]        in_offs;
    logic [15:0]        in_el;
    logic               in_rlim;
    logic               in_xlim;
    logic               in_en;
    logic               in_accept;

    logic [16:0]        ms_sum;
    logic [15:0]        ms_sat;
    logic [31:0]        desired;
    logic               rearm;

    logic signed [58:0] isum;
    logic signed [58:0] lim_s;
    logic signed [26:0] integ_clamped;
    logic signed [32:0] diff_new;
    logic [32:0]        err_abs;
    logic [8:0]         band;
    logic [26:0]        integ_abs;
    logic [32:0]        diff_abs;

    logic signed [appu_pkg::MUL_A_W-1:0] mul_a;
    logic signed [appu_pkg::MUL_B_W-1:0] mul_b;
    logic signed [appu_pkg::MUL_P_W-1:0] prod;

    appu_pkg::div_req_t div_req;
    appu_pkg::div_rsp_t div_rsp;

    logic [55:0]        dmag;
    logic [58:0]        kit_mag;
    logic [58:0]        kdt_mag;
    logic signed [58:0] smax;
    logic signed [58:0] clamped;
    logic signed [15:0] speed_trunc;
    logic signed [15:0] minv;
    logic signed [15:0] fin_speed;
    logic               fin_clear;
    logic               emit_load;

    assign in_enc    = s_axis_tdata[31:0];
    assign in_offs   = s_axis_tdata[47:32];
    assign in_el     = s_axis_tdata[63:48];
    assign in_rlim   = s_axis_tuser[0];
    assign in_xlim   = s_axis_tuser[1];
    assign in_en     = s_axis_tuser[2];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign emit_load     = (state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready);

    // tick bookkeeping at accept
    always_comb
    begin
        ms_sum  = {1'b0, ms_reg} + {1'b0, in_el};
        ms_sat  = ms_sum[16] ? 16'hFFFF : ms_sum[15:0];
        desired = home_position_reg + {{16{in_offs[15]}}, in_offs};
        rearm   = !loop_active_reg || (desired != target_reg);
    end

    // integral update, derivative difference and hold band
    always_comb
    begin
        isum  = 59'(integ_acc_reg) + prod;
        lim_s = $signed({33'b0, lim_reg});
        if (isum > lim_s)
        begin
            integ_clamped = 27'(lim_s);
        end
        else if (isum < -lim_s)
        begin
            integ_clamped = 27'(-lim_s);
        end
        else
        begin
            integ_clamped = isum[26:0];
        end
        diff_new  = 33'(err_reg) - 33'(prev_err_reg);
        err_abs   = err_reg[31] ? (33'd0 - {1'b1, err_reg}) : {1'b0, err_reg};
        band      = {1'b0, deadzone_reg} + appu_pkg::BAND_MARGIN;
        integ_abs = integ_reg[26] ? (27'd0 - integ_reg) : integ_reg;
        diff_abs  = diff_reg[32] ? (33'd0 - diff_reg) : diff_reg;
    end

    // multiplier operand select; the derivative product stays on by default
    always_comb
    begin
        mul_a = $signed({1'b0, diff_abs});
        mul_b = $signed({1'b0, deriv_gain_reg});
        unique case (state_reg)
            S_MUL_ED:
            begin
                mul_a = 34'(err_reg);
                mul_b = $signed({9'b0, dt_reg});
            end
            S_INTEG:
            begin
                mul_a = 34'(err_reg);
                mul_b = $signed({1'b0, prop_gain_reg});
            end
            S_KP:
            begin
                mul_a = $signed({8'b0, integ_abs[25:0]});
                mul_b = $signed({1'b0, integ_gain_reg});
            end
            default:
            begin
                mul_a = $signed({1'b0, diff_abs});
                mul_b = $signed({1'b0, deriv_gain_reg});
            end
        endcase
    end

    appu_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // divider requests: Ki*|integ| / 1000, then Kd*|diff|*1000 / dt
    always_comb
    begin
        dmag = prod[55:0];
        div_req.start    = 1'b0;
        div_req.dividend = {prod[49:0], 16'b0};
        div_req.divisor  = appu_pkg::KI_DIVISOR;
        div_req.steps    = appu_pkg::KI_DIV_STEPS;
        if (state_reg == S_KI_MUL)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == S_KD_SCALE)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = {dmag, 10'b0} - {6'b0, dmag, 4'b0} - {7'b0, dmag, 3'b0};
            div_req.divisor  = dt_reg;
            div_req.steps    = appu_pkg::KD_DIV_STEPS;
        end
    end

    appu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // scaling, saturation and final shaping
    always_comb
    begin
        kit_mag = {17'b0, div_rsp.quot[41:0]};
        kdt_mag = (|div_rsp.quot[65:56]) ? (59'd1 << 56) : {2'b0, div_rsp.quot[56:0]};
        smax    = $signed({28'b0, max_speed_reg, 16'b0});
        if (sum_reg > smax)
        begin
            clamped = smax;
        end
        else if (sum_reg < -smax)
        begin
            clamped = -smax;
        end
        else
        begin
            clamped = sum_reg;
        end
        // truncate toward zero
        speed_trunc = $signed(clamped[31:16])
            + $signed({15'b0, clamped[31] && (|clamped[15:0])});

        minv      = $signed({1'b0, min_speed_reg});
        fin_speed = speed_reg;
        fin_clear = hold_reg;
        if (hold_reg)
        begin
            fin_speed = '0;
        end
        else
        begin
            if ((speed_reg > 16'sd0) && (speed_reg < minv))
            begin
                fin_speed = minv;
            end
            if ((speed_reg < 16'sd0) && (speed_reg > -minv))
            begin
                fin_speed = -minv;
            end
        end
        if ((rlim_reg && (fin_speed < 16'sd0)) || (xlim_reg && (fin_speed > 16'sd0)))
        begin
            fin_speed = '0;
            fin_clear = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (!in_en)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (!rearm && (ms_sat != 16'd0))
                    begin
                        state_next = S_MUL_ED;
                    end
                end
            end
            S_MUL_ED:   state_next = S_INTEG;
            S_INTEG:    state_next = S_KP;
            S_KP:       state_next = S_KI_MUL;
            S_KI_MUL:   state_next = S_KI_DIV;
            S_KI_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_KD_SCALE;
                end
            end
            S_KD_SCALE: state_next = S_KD_DIV;
            S_KD_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_SUM1;
                end
            end
            S_SUM1:     state_next = S_SUM2;
            S_SUM2:     state_next = S_CLAMP;
            S_CLAMP:    state_next = S_FIN;
            S_FIN:      state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            prop_gain_reg      <= appu_pkg::RST_PROP_GAIN;
            integ_gain_reg     <= appu_pkg::RST_INTEG_GAIN;
            deriv_gain_reg     <= appu_pkg::RST_DERIV_GAIN;
            integral_limit_reg <= appu_pkg::RST_INTEGRAL_LIMIT;
            deadzone_reg       <= appu_pkg::RST_DEADZONE;
            max_speed_reg      <= appu_pkg::RST_MAX_SPEED;
            min_speed_reg      <= appu_pkg::RST_MIN_SPEED;
            home_position_reg  <= appu_pkg::RST_HOME_POSITION;
            target_reg         <= '0;
            loop_active_reg    <= 1'b0;
            integ_acc_reg      <= '0;
            prev_err_reg       <= '0;
            ms_reg             <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    appu_pkg::REG_PROP_GAIN:      prop_gain_reg      <= cfg_data[23:0];
                    appu_pkg::REG_INTEG_GAIN:     integ_gain_reg     <= cfg_data[23:0];
                    appu_pkg::REG_DERIV_GAIN:     deriv_gain_reg     <= cfg_data[23:0];
                    appu_pkg::REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[15:0];
                    appu_pkg::REG_DEADZONE:       deadzone_reg       <= cfg_data[7:0];
                    appu_pkg::REG_MAX_SPEED:      max_speed_reg      <= cfg_data[14:0];
                    appu_pkg::REG_MIN_SPEED:      min_speed_reg      <= cfg_data[14:0];
                    appu_pkg::REG_HOME_POSITION:  home_position_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (in_accept)
            begin
                if (!in_en)
                begin
                    ms_reg <= ms_sat;
                end
                else if (rearm)
                begin
                    target_reg      <= desired;
                    integ_acc_reg   <= '0;
                    prev_err_reg    <= '0;
                    ms_reg          <= '0;
                    loop_active_reg <= 1'b1;
                end
                else
                begin
                    // ms_sat of zero leaves zero; otherwise it becomes dt
                    ms_reg <= '0;
                end
            end

            if (state_reg == S_INTEG)
            begin
                prev_err_reg <= err_reg;
            end

            if (state_reg == S_FIN)
            begin
                integ_acc_reg <= fin_clear ? 27'sd0 : integ_reg;
            end

            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        lim_reg <= appu_pkg::times_1000(integral_limit_reg);

        if (in_accept)
        begin
            err_reg       <= $signed(target_reg - in_enc);
            dt_reg        <= ms_sat;
            rlim_reg      <= in_rlim;
            xlim_reg      <= in_xlim;
            res_speed_reg <= '0;
            res_hold_reg  <= 1'b0;
        end

        unique case (state_reg)
            S_INTEG:
            begin
                integ_reg <= integ_clamped;
                diff_reg  <= diff_new;
                hold_reg  <= err_abs <= {24'b0, band};
            end
            S_KP:
            begin
                kpt_reg <= prod;
            end
            S_KI_DIV:
            begin
                if (div_rsp.done)
                begin
                    kit_reg <= integ_reg[26] ? -$signed(kit_mag) : $signed(kit_mag);
                end
            end
            S_KD_DIV:
            begin
                if (div_rsp.done)
                begin
                    kdt_reg <= diff_reg[32] ? -$signed(kdt_mag) : $signed(kdt_mag);
                end
            end
            S_SUM1:
            begin
                sum_reg <= kpt_reg + kit_reg;
            end
            S_SUM2:
            begin
                sum_reg <= sum_reg + kdt_reg;
            end
            S_CLAMP:
            begin
                speed_reg <= speed_trunc;
            end
            S_FIN:
            begin
                res_speed_reg <= fin_speed;
                res_hold_reg  <= hold_reg;
            end
            default: ;
        endcase

        if (emit_load)
        begin
            out_speed_reg <= res_speed_reg;
            out_hold_reg  <= res_hold_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_speed_reg;
    assign m_axis_tuser[0] = out_hold_reg;

    `APPU_ASSERT(a_hold_zero, clk, rst_n, !m_axis_tvalid || !m_axis_tuser[0] || (m_axis_tdata == 16'd0))
    `APPU_ASSERT_NEXT(a_div_runs, clk, rst_n, div_req.start, div_rsp.busy)
    `APPU_ASSERT(a_ready_div_idle, clk, rst_n, !s_axis_tready || !div_rsp.busy)
    `APPU_ASSERT_NEXT(a_loop_sticky, clk, rst_n, loop_active_reg, loop_active_reg)

endmodule

// File: bench/appu_speed_checker.sv
// Scoreboard for the actuator position PID block: watches the tick, speed and config channels.
// Predicts each speed word from its own copy of the loop state; uses appu_pkg register indexes.
`timescale 1ns / 1ps

module appu_speed_checker
    import appu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [63:0]          s_axis_tdata,
    input  logic [2:0]           s_axis_tuser,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [15:0]          m_axis_tdata,
    input  logic [0:0]           m_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   outstanding,
    output int                   fail_count,
    output int                   words_checked,
    output int                   holds_checked
);

    localparam longint DERIV_CAP   = longint'(1) << 56;
    localparam longint HOLD_MARGIN = 10;

    typedef struct packed {
        logic [15:0] speed;
        logic        hold;
    } speed_word_t;

    speed_word_t expected_words[$];

    // register copies
    logic [23:0] kp, ki, kd;
    logic [15:0] i_lim;
    logic [7:0]  band_base;
    logic [14:0] spd_max, spd_min;
    logic [31:0] home;

    // loop state
    logic [31:0]        goal_count;
    bit                 loop_armed;
    logic signed [31:0] integ_tickms;
    logic signed [31:0] last_error;
    logic [15:0]        ms_pending;

    int fails, checked, holds;

    // Returns 1 when the tick produces a speed word.
    function automatic bit next_command(input logic [31:0] enc, input logic [15:0] offs,
                                        input logic [15:0] el, input bit rlim, input bit xlim,
                                        input bit en, output logic [15:0] spd, output bit hold);
        logic [16:0]        t_sum;
        logic [31:0]        want;
        logic signed [31:0] err32;
        longint             err, dt, lim, integ, diff, kpt, kit, kdt, sum, smax, speed, mag;
        longint unsigned    dmag, q, rem, udt;
        spd = '0;
        hold = 1'b0;
        t_sum = {1'b0, ms_pending} + {1'b0, el};
        ms_pending = t_sum[16] ? 16'hFFFF : t_sum[15:0];
        if (!en)
            return 1'b1;

        want = home + {{16{offs[15]}}, offs};
        if (!loop_armed || want != goal_count)
        begin
            goal_count = want;
            integ_tickms = '0;
            last_error = '0;
            ms_pending = '0;
            loop_armed = 1'b1;
            return 1'b0;
        end
        if (ms_pending == 16'd0)
            return 1'b0;
        dt = longint'(ms_pending);
        ms_pending = '0;

        err32 = goal_count - enc;
        err = longint'(err32);

        lim = longint'(i_lim) * 1000;
        integ = longint'(integ_tickms) + err * dt;
        if (integ > lim)
            integ = lim;
        if (integ < -lim)
            integ = -lim;

        diff = err - longint'(last_error);
        last_error = err32;

        kpt = longint'(kp) * err;

        mag = longint'(ki) * ((integ < 0) ? -integ : integ);
        kit = mag / 1000;
        if (integ < 0)
            kit = -kit;

        // derivative in Q16 per second, magnitude capped
        dmag = longint'(kd) * ((diff < 0) ? -diff : diff);
        udt = dt;
        q = dmag / udt;
        rem = dmag % udt;
        if (q >= (64'd1 << 46))
            kdt = DERIV_CAP;
        else
        begin
            kdt = q * 1000 + (rem * 1000) / udt;
            if (kdt > DERIV_CAP)
                kdt = DERIV_CAP;
        end
        if (diff < 0)
            kdt = -kdt;

        sum = kpt + kit + kdt;

        mag = (err < 0) ? -err : err;
        if (mag <= longint'(band_base) + HOLD_MARGIN)
        begin
            speed = 0;
            hold = 1'b1;
            integ = 0;
        end
        else
        begin
            smax = longint'(spd_max) * 65536;
            if (sum > smax)
                sum = smax;
            if (sum < -smax)
                sum = -smax;
            speed = sum / 65536;
            // lift comes after saturation, so min wins over max
            if (speed > 0 && speed < longint'(spd_min))
                speed = longint'(spd_min);
            if (speed < 0 && speed > -longint'(spd_min))
                speed = -longint'(spd_min);
        end

        if ((rlim && speed < 0) || (xlim && speed > 0))
        begin
            speed = 0;
            integ = 0;
        end

        integ_tickms = integ[31:0];
        spd = speed[15:0];
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        speed_word_t want;
        logic [15:0] spd;
        bit          hold;
        if (!rst_n)
        begin
            kp = RST_PROP_GAIN;
            ki = RST_INTEG_GAIN;
            kd = RST_DERIV_GAIN;
            i_lim = RST_INTEGRAL_LIMIT;
            band_base = RST_DEADZONE;
            spd_max = RST_MAX_SPEED;
            spd_min = RST_MIN_SPEED;
            home = RST_HOME_POSITION;
            goal_count = '0;
            loop_armed = 1'b0;
            integ_tickms = '0;
            last_error = '0;
            ms_pending = '0;
            expected_words.delete();
            fails = 0;
            checked = 0;
            holds = 0;
            outstanding <= 0;
            fail_count <= 0;
            words_checked <= 0;
            holds_checked <= 0;
        end
        else
        begin
            // compare first: a word leaving now never belongs to a tick taken now
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected speed word: speed_cmd %0d holding %0b",
                           $signed(m_axis_tdata), m_axis_tuser[0]);
                    fails++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    checked++;
                    if (want.hold)
                        holds++;
                    if (m_axis_tdata !== want.speed)
                    begin
                        $error("speed_cmd: expected %0d, actual %0d",
                               $signed(want.speed), $signed(m_axis_tdata));
                        fails++;
                    end
                    if (m_axis_tuser[0] !== want.hold)
                    begin
                        $error("holding: expected %0b, actual %0b", want.hold, m_axis_tuser[0]);
                        fails++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:      kp = cfg_data[23:0];
                    REG_INTEG_GAIN:     ki = cfg_data[23:0];
                    REG_DERIV_GAIN:     kd = cfg_data[23:0];
                    REG_INTEGRAL_LIMIT: i_lim = cfg_data[15:0];
                    REG_DEADZONE:       band_base = cfg_data[7:0];
                    REG_MAX_SPEED:      spd_max = cfg_data[14:0];
                    REG_MIN_SPEED:      spd_min = cfg_data[14:0];
                    REG_HOME_POSITION:  home = cfg_data;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (next_command(s_axis_tdata[31:0], s_axis_tdata[47:32], s_axis_tdata[63:48],
                                 s_axis_tuser[0], s_axis_tuser[1], s_axis_tuser[2], spd, hold))
                    expected_words.push_back({spd, hold});
            end

            outstanding <= expected_words.size();
            fail_count <= fails;
            words_checked <= checked;
            holds_checked <= holds;
        end
    end

endmodule

// File: bench/actuator_position_pid_unit_test.sv
// Testbench top for actuator_position_pid_unit: clock, reset, tick and config stimulus, verdict.
// Depends on appu_pkg, the block itself and appu_speed_checker.
`timescale 1ns / 1ps

module actuator_position_pid_unit_test;
    import appu_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_LIMIT   = 3000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 229;

    logic                 clk = 1'b0;
    logic                 rst_n;
    // s_axis_tdata: [31:0] encoder_count, [47:32] setpoint_offset, [63:48] elapsed_ms
    logic [63:0]          s_axis_tdata;
    // s_axis_tuser: [0] retract_limit, [1] extend_limit, [2] enable
    logic [2:0]           s_axis_tuser;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // m_axis_tdata: [15:0] speed_cmd
    logic [15:0]          m_axis_tdata;
    // m_axis_tuser: [0] holding
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int outstanding, fail_count, words_checked, holds_checked;
    int ticks_sent, settings_used;
    bit steady;
    logic [31:0] home_mirror;
    logic [7:0]  band_mirror;

    always #2 clk = ~clk;

    actuator_position_pid_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    appu_speed_checker speed_check (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .outstanding(outstanding),
        .fail_count(fail_count),
        .words_checked(words_checked),
        .holds_checked(holds_checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_pause(input int longest);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, longest);
    endfunction

    function automatic logic [15:0] pick_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'd0;
        if (r < 10)
            return 16'd1;
        if (r < 80)
            return 16'($urandom_range(5, 100));
        if (r < 95)
            return 16'($urandom_range(100, 2000));
        if (r < 99)
            return 16'($urandom());
        return 16'hFFFF;
    endfunction

    // error around the hold band edge, small, medium, or anywhere in 32 bits
    function automatic longint pick_error();
        longint band;
        int     r;
        band = longint'(band_mirror) + 10;
        r = $urandom_range(0, 99);
        if (r < 20)
            return longint'($urandom_range(0, 2 * band)) - band;
        if (r < 35)
            return ($urandom_range(0, 1) ? longint'(1) : longint'(-1))
                   * (band + longint'($urandom_range(1, 3)));
        if (r < 70)
            return longint'($urandom_range(0, 4000)) - 2000;
        if (r < 90)
            return longint'($urandom_range(0, 2000000)) - 1000000;
        return longint'($signed($urandom()));
    endfunction

    task automatic put_tick(input logic [31:0] enc, input logic [15:0] offs,
                            input logic [15:0] ms, input bit rl, input bit xl, input bit en);
        int gap;
        cfg_valid <= 1'b0;      // config channel stays quiet while ticks flow
        s_axis_tdata <= {ms, offs, enc};
        s_axis_tuser <= {en, xl, rl};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        ticks_sent++;
        gap = steady ? 0 : pick_pause(40);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (idx == REG_DEADZONE)
            band_mirror = value[7:0];
        if (idx == REG_HOME_POSITION)
            home_mirror = value;
    endtask

    // hold the sender until every speed word is back; optionally let the block go idle
    task automatic quiesce(input bit settle);
        s_axis_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        if (settle)
            repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(input int phase);
        logic [31:0] vals [0:7];
        case (phase)
            0:
            begin
                vals[REG_PROP_GAIN] = RST_PROP_GAIN;
                vals[REG_INTEG_GAIN] = RST_INTEG_GAIN;
                vals[REG_DERIV_GAIN] = RST_DERIV_GAIN;
                vals[REG_INTEGRAL_LIMIT] = RST_INTEGRAL_LIMIT;
                vals[REG_DEADZONE] = RST_DEADZONE;
                vals[REG_MAX_SPEED] = RST_MAX_SPEED;
                vals[REG_MIN_SPEED] = RST_MIN_SPEED;
                vals[REG_HOME_POSITION] = RST_HOME_POSITION;
            end
            1:
            begin
                vals[REG_PROP_GAIN] = 32'hFF_FFFF;
                vals[REG_INTEG_GAIN] = 32'hFF_FFFF;
                vals[REG_DERIV_GAIN] = 32'hFF_FFFF;
                vals[REG_INTEGRAL_LIMIT] = 32'hFFFF;
                vals[REG_DEADZONE] = 32'hFF;
                vals[REG_MAX_SPEED] = 32'h7FFF;
                vals[REG_MIN_SPEED] = 32'h7FFF;
                vals[REG_HOME_POSITION] = 32'h7FFF_FFFF;
            end
            2:
            begin
                vals[REG_PROP_GAIN] = '0;
                vals[REG_INTEG_GAIN] = '0;
                vals[REG_DERIV_GAIN] = '0;
                vals[REG_INTEGRAL_LIMIT] = '0;
                vals[REG_DEADZONE] = '0;
                vals[REG_MAX_SPEED] = '0;
                vals[REG_MIN_SPEED] = '0;
                vals[REG_HOME_POSITION] = 32'h8000_0000;
            end
            3:
            begin
                // min above max
                vals[REG_PROP_GAIN] = $urandom_range(0, 24'h3_FFFF);
                vals[REG_INTEG_GAIN] = $urandom_range(0, 24'h00_FFFF);
                vals[REG_DERIV_GAIN] = $urandom_range(0, 24'h0F_FFFF);
                vals[REG_INTEGRAL_LIMIT] = $urandom_range(0, 16'hFFFF);
                vals[REG_DEADZONE] = $urandom_range(0, 20);
                vals[REG_MAX_SPEED] = $urandom_range(0, 200);
                vals[REG_MIN_SPEED] = vals[REG_MAX_SPEED] + $urandom_range(1, 3000);
                vals[REG_HOME_POSITION] = $urandom();
            end
            default:
            begin
                vals[REG_PROP_GAIN] = ($urandom_range(0, 3) == 0)
                                      ? $urandom_range(0, 24'hFF_FFFF)
                                      : $urandom_range(0, 24'h07_FFFF);
                vals[REG_INTEG_GAIN] = ($urandom_range(0, 3) == 0)
                                       ? $urandom_range(0, 24'hFF_FFFF)
                                       : $urandom_range(0, 24'h00_FFFF);
                case ($urandom_range(0, 3))
                    0: vals[REG_DERIV_GAIN] = '0;
                    1: vals[REG_DERIV_GAIN] = $urandom_range(0, 24'hFF_FFFF);
                    default: vals[REG_DERIV_GAIN] = $urandom_range(0, 24'h03_FFFF);
                endcase
                vals[REG_INTEGRAL_LIMIT] = $urandom_range(0, 16'hFFFF);
                vals[REG_DEADZONE] = ($urandom_range(0, 3) == 0)
                                     ? $urandom_range(0, 255) : $urandom_range(0, 20);
                vals[REG_MAX_SPEED] = $urandom_range(0, 15'h7FFF);
                vals[REG_MIN_SPEED] = ($urandom_range(0, 3) == 0)
                                      ? $urandom_range(0, 15'h7FFF) : $urandom_range(0, 200);
                vals[REG_HOME_POSITION] = $urandom();
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(i[CFG_IDX_W-1:0], vals[i]);
        settings_used++;
    endtask

    // arm on a setpoint, then track an encoder that mostly closes in on it
    task automatic drive_run(input int length);
        logic [15:0] offs;
        logic [31:0] target;
        longint      cur_err;
        int          kind;
        steady = ($urandom_range(0, 3) == 0);
        offs = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 2000) - 1000)
                                          : 16'($urandom());
        target = home_mirror + {{16{offs[15]}}, offs};
        cur_err = pick_error();
        put_tick(target - cur_err[31:0], offs, pick_ms(), 1'b0, 1'b0, 1'b1);
        for (int i = 0; i < length; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 5)
            begin
                put_tick($urandom(), offs, pick_ms(), $urandom_range(0, 1),
                         $urandom_range(0, 1), 1'b0);
                continue;
            end
            if (kind < 8)
            begin
                offs = 16'($urandom());
                target = home_mirror + {{16{offs[15]}}, offs};
            end
            if ($urandom_range(0, 7) == 0)
                cur_err = pick_error();
            else
                cur_err = cur_err - cur_err / 4 + longint'($urandom_range(0, 6)) - 3;
            put_tick(target - cur_err[31:0], offs, pick_ms(), ($urandom_range(0, 9) == 0),
                     ($urandom_range(0, 9) == 0), 1'b1);
        end
    endtask

    // speed side: ready runs and stalls, sometimes a long ready stretch
    initial
    begin : sink_pacing
        int run_len, stall_len;
        forever
        begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(1, 8);
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall_len = pick_pause(60);
            if (stall_len > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int phase_end, r;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        home_mirror = RST_HOME_POSITION;
        band_mirror = RST_DEADZONE;
        steady = 1'b0;
        ticks_sent = 0;
        settings_used = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset setting, home at zero, band of 11 ticks
        put_tick(32'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);              // disabled
        put_tick(32'd0, 16'd0, 16'd10, 1'b0, 1'b0, 1'b1);             // first target arms
        put_tick(32'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1);              // no time elapsed
        put_tick(-32'sd5, 16'd0, 16'd20, 1'b0, 1'b0, 1'b1);           // inside band
        put_tick(-32'sd1000, 16'd0, 16'd20, 1'b0, 1'b0, 1'b1);
        put_tick(32'sd1000, 16'd0, 16'd20, 1'b1, 1'b0, 1'b1);         // retract switch blocks
        put_tick(-32'sd2000, 16'd0, 16'd20, 1'b0, 1'b1, 1'b1);        // extend switch blocks
        put_tick(32'sd1000, 16'd0, 16'd20, 1'b0, 1'b1, 1'b1);         // wrong switch, passes
        put_tick(-32'sd12, 16'd0, 16'd20, 1'b0, 1'b0, 1'b1);          // just outside band
        put_tick(32'd0, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0);           // elapsed time saturates
        put_tick(32'd0, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        put_tick(-32'sd1073741824, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1);   // integral clamp
        put_tick(32'h8000_0000, 16'h7FFF, 16'd5, 1'b0, 1'b0, 1'b1);   // re-arm at extreme
        put_tick(32'h8000_0000, 16'h7FFF, 16'd1, 1'b0, 1'b0, 1'b1);   // error wraps
        put_tick(32'h7FFF_FFFF, 16'h8000, 16'd5, 1'b1, 1'b1, 1'b1);
        put_tick(32'h7FFF_FFFF, 16'h8000, 16'hFFFF, 1'b1, 1'b0, 1'b1);

        quiesce(1'b1);
        write_reg(REG_PROP_GAIN, 32'h1_0000);
        write_reg(REG_INTEG_GAIN, 32'd0);
        write_reg(REG_DERIV_GAIN, 32'hFF_FFFF);
        put_tick(32'd0, 16'd0, 16'd3, 1'b0, 1'b0, 1'b1);
        put_tick(-32'sd1073741824, 16'd0, 16'd1, 1'b0, 1'b0, 1'b1);   // derivative cap
        put_tick(-32'sd12, 16'd0, 16'd1, 1'b0, 1'b0, 1'b1);
        put_tick(-32'sd12, 16'd0, 16'd50, 1'b0, 1'b0, 1'b1);          // lifted to min speed

        quiesce(1'b1);
        write_reg(REG_MAX_SPEED, 32'd20);
        write_reg(REG_MIN_SPEED, 32'd40);
        put_tick(-32'sd500, 16'd0, 16'd10, 1'b0, 1'b0, 1'b1);         // min above max
        put_tick(32'sd500, 16'd0, 16'd10, 1'b0, 1'b0, 1'b1);
        settings_used += 2;

        for (int p = 0; p < PHASES; p++)
        begin
            quiesce(1'b1);
            load_setting(p);
            phase_end = ticks_sent + PHASE_ITEMS;
            while (ticks_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    steady = 1'b0;
                    put_tick($urandom(), 16'($urandom()),
                             ($urandom_range(0, 1) ? pick_ms() : 16'($urandom())),
                             $urandom_range(0, 1), $urandom_range(0, 1),
                             ($urandom_range(0, 3) != 0));
                end
                else if (r < 14)
                    quiesce(1'b0);
                else
                    drive_run($urandom_range(3, 20));
            end
        end

        quiesce(1'b1);
        $display("summary: %0d ticks over %0d register settings, %0d speed words checked",
                 ticks_sent, settings_used, words_checked);
        $display("summary: %0d of them in the hold band", holds_checked);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/appu_pkg.sv
rtl/appu_mul.sv
rtl/appu_div.sv
rtl/actuator_position_pid_unit.sv
bench/appu_speed_checker.sv
bench/actuator_position_pid_unit_test.sv
